@@ hdl/bsme_pkg.sv @@
// Shared constants, types and state codes of the bad-sector map engine.
`default_nettype none
package bsme_pkg;

    localparam int MAP_BYTES = 32768;
    localparam int AW        = $clog2(MAP_BYTES);
    localparam int PW        = AW + 1;
    localparam int MASK_SEGS = MAP_BYTES / 4;

    localparam logic [PW-1:0] ENT_LAST = PW'(MAP_BYTES - 3);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAP_BYTES - 1);
    localparam logic [18:0]   SEG_NONE = 19'h7FFFF;
    localparam logic [17:0]   SEG_TOP  = 18'h3FFFF;
    localparam logic [23:0]   FLAG_BIT = 24'h800000;
    localparam logic [31:0]   ALL_ONES = 32'hFFFFFFFF;

    localparam logic [1:0] FMT_LIST = 2'd1;
    localparam logic [1:0] FMT_FLAG = 2'd2;

    localparam logic CFG_FORMAT = 1'b0;
    localparam logic CFG_HEADER = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_READ = 2'd1,
        OP_GET  = 2'd2,
        OP_PUT  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [17:0] seg;
        logic [31:0] nm;
        logic [14:0] idx;
        logic [7:0]  bv;
    } t_req;

    typedef struct packed {
        logic [31:0] mask;
        logic [7:0]  rv;
        logic        st;
        logic        changed;
    } t_res;

    typedef struct packed {
        logic [1:0] fmt;
        logic       hdr;
    } t_cfg;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DEC, S_RDB, S_WRD, S_WWR, S_PCNT, S_FETCH,
        S_FWDA, S_FWDB, S_FEND, S_ESCAN, S_MCHK, S_MSET, S_MVR, S_MVW,
        S_WBIT, S_WENT, S_PUTOK, S_BKB, S_BKC, S_DONE
    } t_state;

endpackage
`default_nettype wire

@@ hdl/bsme_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module bsme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ hdl/bsme_engine.sv @@
// Sequencer that walks, rewrites and shifts the map held in the byte store.
`default_nettype none
module bsme_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bsme_pkg::t_cfg  i_cfg,
    input  wire logic            i_start,
    input  wire bsme_pkg::t_req  i_req,
    output logic                 o_ready,
    input  wire logic            i_res_free,
    output logic                 o_done,
    output bsme_pkg::t_res       o_res
);
    import bsme_pkg::*;

    t_state r_state, n_state, r_ret, n_ret;
    t_req   r_req, n_req;
    logic [AW-1:0] r_clr, n_clr;
    logic [2:0]    r_k, n_k;
    logic [PW-1:0] r_fa, n_fa, r_start, n_start, r_cnt, n_cnt, r_e, n_e;
    logic [PW-1:0] r_src, n_src, r_dst, n_dst, r_len, n_len, r_cursor, n_cursor;
    logic [23:0]   r_ent, n_ent;
    logic [31:0]   r_m, n_m, r_cached, n_cached, r_rmask, n_rmask;
    logic [7:0]    r_rrv, n_rrv;
    logic          r_rst, n_rst, r_changed, n_changed, r_flg, n_flg, r_dn, n_dn;
    logic [5:0]    r_n, n_n;
    logic [4:0]    r_i, n_i;
    logic [18:0]   r_last, n_last;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wd, ram_rd;

    logic [22:0] e_dec;
    logic [17:0] e_seg;
    logic [31:0] e_bit;
    logic        e_flag, e_nz, e_gt, e_lt, fl2, lst;
    logic        fa_oor, fa_lt3, idx_ok, word_ok, get_fwd, get_back, too_high, cnt_ne;
    logic [PW-1:0] fa_p3, fa_m3, c3, n3, newend;
    logic [1:0]  kb;
    logic [AW-1:0] wa, fa_a;
    logic [23:0] wv;

    bsme_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wd),
        .o_rdata (ram_rd)
    );

    // Entry decode: the sector number is one-based and the flag never counts.
    assign e_dec  = r_ent[22:0] - 23'd1;
    assign e_seg  = e_dec[22:5];
    assign e_bit  = 32'd1 << e_dec[4:0];
    assign e_flag = r_ent[23];
    assign e_nz   = |r_ent;
    assign e_gt   = e_seg > r_req.seg;
    assign e_lt   = e_seg < r_req.seg;
    assign fl2    = i_cfg.fmt == FMT_FLAG;
    assign lst    = (i_cfg.fmt == FMT_LIST) || (i_cfg.fmt == FMT_FLAG);
    assign fa_oor = r_fa > ENT_LAST;
    assign fa_lt3 = r_fa < PW'(3);
    assign fa_p3  = r_fa + PW'(3);
    assign fa_m3  = r_fa - PW'(3);
    assign fa_a   = r_fa[AW-1:0];
    assign kb     = 2'(r_k - 3'd1);
    assign idx_ok = 32'(r_req.idx) < MAP_BYTES;
    assign word_ok = 32'(r_req.seg) < MASK_SEGS;
    assign wa     = AW'({r_req.seg, 2'b00});
    assign get_fwd  = (r_last == SEG_NONE) || ({1'b0, r_req.seg} > r_last);
    assign get_back = {1'b0, r_req.seg} < r_last;
    assign too_high = !(fl2 && (r_req.nm == ALL_ONES)) && r_req.nm[31]
                      && (r_req.seg == SEG_TOP);
    assign cnt_ne = r_cnt != PW'(r_n);
    assign c3     = (r_cnt << 1) + r_cnt;
    assign n3     = PW'({r_n, 1'b0}) + PW'(r_n);
    assign newend = r_e + n3 - c3;
    assign wv     = r_flg ? (FLAG_BIT | ({1'b0, r_req.seg, 5'd0} + 24'd1))
                          : ({1'b0, r_req.seg, r_i} + 24'd1);

    assign o_ready = r_state == S_IDLE;
    assign o_done  = (r_state == S_DONE) && i_res_free;
    assign o_res   = '{mask: r_rmask, rv: r_rrv, st: r_rst, changed: r_changed};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == CLR_LAST) n_state = S_IDLE;
            S_IDLE:  if (i_start) n_state = S_DEC;
            S_DEC: begin
                unique case (r_req.op)
                    OP_LOAD: n_state = S_DONE;
                    OP_READ: n_state = idx_ok ? S_RDB : S_DONE;
                    OP_GET: begin
                        if (i_cfg.hdr) n_state = S_DONE;
                        else if (lst) begin
                            if (get_fwd) n_state = S_FETCH;
                            else if (get_back) n_state = (r_cursor < PW'(3)) ? S_DONE : S_FETCH;
                            else n_state = S_DONE;
                        end else n_state = word_ok ? S_WRD : S_DONE;
                    end
                    OP_PUT: begin
                        if (lst) n_state = too_high ? S_DONE : S_PCNT;
                        else n_state = word_ok ? S_WWR : S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RDB:   n_state = S_DONE;
            S_WRD:   if (r_k == 3'd4) n_state = S_DONE;
            S_WWR:   if (r_k == 3'd3) n_state = S_DONE;
            S_PCNT:  if (r_i == 5'd31) n_state = S_FETCH;
            S_FETCH: if ((r_k == 3'd0 && fa_oor) || r_k == 3'd3) n_state = r_ret;
            S_FWDA: begin
                if (e_nz && e_lt) n_state = S_FETCH;
                else if (fl2 && e_flag && !e_gt) n_state = S_FEND;
                else if (e_nz && !e_gt) n_state = S_FETCH;
                else n_state = S_FEND;
            end
            S_FWDB:  n_state = (e_nz && !e_lt && !e_gt) ? S_FETCH : S_FEND;
            S_FEND: begin
                if (r_req.op == OP_GET) n_state = S_DONE;
                else n_state = cnt_ne ? S_FETCH : S_WBIT;
            end
            S_ESCAN: begin
                if (fa_oor) n_state = S_DONE;
                else if (e_nz) n_state = S_FETCH;
                else n_state = S_MCHK;
            end
            S_MCHK:  n_state = (newend > ENT_LAST) ? S_DONE : S_MSET;
            S_MSET:  n_state = S_MVR;
            S_MVR:   n_state = S_MVW;
            S_MVW:   n_state = (r_len == PW'(1)) ? S_WBIT : S_MVR;
            S_WBIT: begin
                if (r_flg || r_req.nm[r_i]) n_state = S_WENT;
                else if (r_i == 5'd31) n_state = S_PUTOK;
            end
            S_WENT: begin
                if (r_k == 3'd2) n_state = (r_flg || r_i == 5'd31) ? S_PUTOK : S_WBIT;
            end
            S_PUTOK: n_state = S_DONE;
            S_BKB: begin
                if (!fa_lt3 && e_gt) n_state = S_FETCH;
                else if (e_gt || e_lt || (fl2 && e_flag) || fa_lt3) n_state = S_DONE;
                else n_state = S_FETCH;
            end
            S_BKC:   n_state = (!e_lt && !e_gt && !fa_lt3) ? S_FETCH : S_DONE;
            S_DONE:  if (i_res_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and store accesses.
    always_comb begin
        n_ret = r_ret;       n_req = r_req;     n_clr = r_clr;     n_k = r_k;
        n_fa = r_fa;         n_start = r_start; n_cnt = r_cnt;     n_e = r_e;
        n_src = r_src;       n_dst = r_dst;     n_len = r_len;     n_cursor = r_cursor;
        n_ent = r_ent;       n_m = r_m;         n_cached = r_cached;
        n_rmask = r_rmask;   n_rrv = r_rrv;     n_rst = r_rst;     n_changed = r_changed;
        n_flg = r_flg;       n_dn = r_dn;       n_n = r_n;         n_i = r_i;
        n_last = r_last;
        ram_we = 1'b0;
        ram_addr = '0;
        ram_wd = 8'd0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_addr = r_clr;
                n_clr = r_clr + AW'(1);
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    n_rmask = 32'd0;
                    n_rrv = 8'd0;
                    n_rst = 1'b0;
                    n_k = 3'd0;
                end
            end
            S_DEC: begin
                case (r_req.op)
                    OP_LOAD: begin
                        if (idx_ok) begin
                            ram_we = 1'b1;
                            ram_addr = AW'(r_req.idx);
                            ram_wd = r_req.bv;
                        end else n_rst = 1'b1;
                    end
                    OP_READ: begin
                        if (idx_ok) ram_addr = AW'(r_req.idx);
                        else n_rst = 1'b1;
                    end
                    OP_GET: begin
                        if (i_cfg.hdr) n_cached = 32'd0;
                        else if (lst) begin
                            n_m = 32'd0;
                            n_cnt = '0;
                            if (get_fwd) begin
                                n_fa = r_cursor;
                                n_ret = S_FWDA;
                            end else if (get_back) begin
                                if (r_cursor < PW'(3)) begin
                                    n_cached = 32'd0;
                                    n_last = {1'b0, r_req.seg};
                                end else begin
                                    n_fa = r_cursor - PW'(3);
                                    n_ret = S_BKB;
                                end
                            end else n_rmask = r_cached;
                        end else if (!word_ok) n_rst = 1'b1;
                    end
                    OP_PUT: begin
                        if (lst) begin
                            if (too_high) n_rst = 1'b1;
                            n_i = 5'd0;
                            n_n = 6'd0;
                            n_flg = fl2 && (r_req.nm == ALL_ONES);
                        end else if (!word_ok) n_rst = 1'b1;
                    end
                    default: n_rst = 1'b1;
                endcase
            end
            S_RDB: n_rrv = ram_rd;
            S_WRD: begin
                ram_addr = wa + AW'(r_k);
                if (r_k != 3'd0) n_m[{kb, 3'b000} +: 8] = ram_rd;
                n_k = r_k + 3'd1;
                if (r_k == 3'd4) begin
                    n_cached = {ram_rd, r_m[23:0]};
                    n_rmask = {ram_rd, r_m[23:0]};
                    n_k = 3'd0;
                end
            end
            S_WWR: begin
                ram_we = 1'b1;
                ram_addr = wa + AW'(r_k);
                ram_wd = r_req.nm[{r_k[1:0], 3'b000} +: 8];
                n_k = r_k + 3'd1;
                if (r_k == 3'd3) begin
                    n_k = 3'd0;
                    n_changed = 1'b1;
                    n_cursor = '0;
                    n_last = SEG_NONE;
                    n_cached = 32'd0;
                end
            end
            S_PCNT: begin
                n_n = r_n + 6'(r_req.nm[r_i]);
                n_i = r_i + 5'd1;
                if (r_i == 5'd31) begin
                    // A whole-segment entry stands for one entry.
                    if (r_flg) n_n = 6'd1;
                    n_fa = '0;
                    n_ret = S_FWDA;
                    n_m = 32'd0;
                    n_cnt = '0;
                    n_k = 3'd0;
                end
            end
            S_FETCH: begin
                if (r_k == 3'd0 && fa_oor) begin
                    n_ent = 24'd0;
                end else begin
                    ram_addr = fa_a + AW'(r_k);
                    if (r_k != 3'd0) n_ent[{kb, 3'b000} +: 8] = ram_rd;
                    n_k = (r_k == 3'd3) ? 3'd0 : r_k + 3'd1;
                end
            end
            S_FWDA: begin
                if (e_nz && e_lt) begin
                    n_fa = fa_p3;
                end else begin
                    n_start = r_fa;
                    if (fl2 && e_flag && !e_gt) begin
                        n_m = ALL_ONES;
                        n_cnt = PW'(1);
                    end else if (e_nz && !e_gt) begin
                        n_m = e_bit;
                        n_cnt = PW'(1);
                        n_fa = fa_p3;
                        n_ret = S_FWDB;
                    end else begin
                        n_m = 32'd0;
                        n_cnt = '0;
                    end
                end
            end
            S_FWDB: begin
                if (e_nz && !e_lt && !e_gt) begin
                    n_m = r_m | e_bit;
                    n_cnt = r_cnt + PW'(1);
                    n_fa = fa_p3;
                end
            end
            S_FEND: begin
                n_fa = r_start;
                n_i = 5'd0;
                if (r_req.op == OP_GET) begin
                    n_cursor = r_start;
                    n_cached = r_m;
                    n_last = {1'b0, r_req.seg};
                    n_rmask = r_m;
                end else n_ret = S_ESCAN;
            end
            S_ESCAN: begin
                if (fa_oor) n_rst = 1'b1;
                else if (e_nz) n_fa = fa_p3;
                else n_e = r_fa;
            end
            S_MCHK: begin
                if (newend > ENT_LAST) n_rst = 1'b1;
                n_src = r_start + c3;
                n_dst = r_start + n3;
                n_len = r_e + PW'(3) - (r_start + c3);
                n_dn = n3 > c3;
            end
            S_MSET: begin
                // Moving toward higher addresses copies from the top down.
                if (r_dn) begin
                    n_src = r_src + r_len - PW'(1);
                    n_dst = r_dst + r_len - PW'(1);
                end
            end
            S_MVR: ram_addr = r_src[AW-1:0];
            S_MVW: begin
                ram_we = 1'b1;
                ram_addr = r_dst[AW-1:0];
                ram_wd = ram_rd;
                n_src = r_dn ? r_src - PW'(1) : r_src + PW'(1);
                n_dst = r_dn ? r_dst - PW'(1) : r_dst + PW'(1);
                n_len = r_len - PW'(1);
                n_fa = r_start;
                n_i = 5'd0;
            end
            S_WBIT: begin
                n_k = 3'd0;
                if (!(r_flg || r_req.nm[r_i])) n_i = r_i + 5'd1;
            end
            S_WENT: begin
                if (!fa_oor) begin
                    ram_we = 1'b1;
                    ram_addr = fa_a + AW'(r_k);
                    ram_wd = wv[{r_k[1:0], 3'b000} +: 8];
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd2) begin
                    n_k = 3'd0;
                    n_fa = fa_p3;
                    n_i = r_i + 5'd1;
                end
            end
            S_PUTOK: begin
                n_changed = 1'b1;
                n_cursor = '0;
                n_last = SEG_NONE;
                n_cached = 32'd0;
            end
            S_BKB: begin
                if (!fa_lt3 && e_gt) begin
                    n_fa = fa_m3;
                end else if (e_gt || e_lt || (fl2 && e_flag) || fa_lt3) begin
                    n_cursor = e_lt ? fa_p3 : r_fa;
                    n_m = e_gt || e_lt ? 32'd0 : ((fl2 && e_flag) ? ALL_ONES : e_bit);
                    n_cached = n_m;
                    n_rmask = n_m;
                    n_last = {1'b0, r_req.seg};
                end else begin
                    n_m = e_bit;
                    n_fa = fa_m3;
                    n_ret = S_BKC;
                end
            end
            S_BKC: begin
                if (!e_lt && !e_gt) begin
                    n_m = r_m | e_bit;
                    if (fa_lt3) begin
                        n_cursor = r_fa;
                        n_cached = r_m | e_bit;
                        n_rmask = r_m | e_bit;
                        n_last = {1'b0, r_req.seg};
                    end else n_fa = fa_m3;
                end else begin
                    n_cursor = e_lt ? fa_p3 : r_fa;
                    n_cached = r_m;
                    n_rmask = r_m;
                    n_last = {1'b0, r_req.seg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_k       <= 3'd0;
            r_cursor  <= '0;
            r_last    <= SEG_NONE;
            r_cached  <= 32'd0;
            r_changed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_k       <= n_k;
            r_cursor  <= n_cursor;
            r_last    <= n_last;
            r_cached  <= n_cached;
            r_changed <= n_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;     r_req <= n_req;     r_fa <= n_fa;       r_start <= n_start;
        r_cnt <= n_cnt;     r_e <= n_e;         r_src <= n_src;     r_dst <= n_dst;
        r_len <= n_len;     r_ent <= n_ent;     r_m <= n_m;         r_rmask <= n_rmask;
        r_rrv <= n_rrv;     r_rst <= n_rst;     r_flg <= n_flg;     r_dn <= n_dn;
        r_n <= n_n;         r_i <= n_i;
    end
endmodule
`default_nettype wire

@@ hdl/bad_sector_map_engine.sv @@
// Top level of the bad-sector map engine: stream ports, settings and result register.
//
//  Channel   Direction  Payload (lowest bit first)
//  s_axis    in         tuser: opcode; tdata: segment, new_mask, byte_index, byte_value
//  m_axis    out        tdata: mask, read_value, status, changed
//  i_cfg_*   in         index 0 map_format, index 1 header_pending
//
// A list get walks entries from the cursor, reading each entry a byte at a time from the
// single byte port. A list put first counts the bits of the new mask, then scans the
// entries, shifts the tail one byte at a time where the entry count changes and writes
// the new entries. After reset a clearing pass writes all MAP_BYTES bytes, one per cycle,
// before the first request; settings writes are taken throughout. A finished result
// waits in the output register while the next request is taken.
`default_nettype none
module bad_sector_map_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // segment, new_mask, byte_index, byte_value
    input  wire logic [1:0]  s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata   // mask, read_value, status, changed
);
    import bsme_pkg::*;

    t_cfg  r_cfg;
    t_req  req;
    t_res  res;
    logic  r_ovalid, eng_ready, done, res_free;
    logic [41:0] r_odata;

    assign req = '{op: t_op'(s_axis_tuser), seg: s_axis_tdata[17:0],
                   nm: s_axis_tdata[49:18], idx: s_axis_tdata[64:50],
                   bv: s_axis_tdata[72:65]};
    assign res_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = eng_ready;

    bsme_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (s_axis_tvalid && eng_ready),
        .i_req      (req),
        .o_ready    (eng_ready),
        .i_res_free (res_free),
        .o_done     (done),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= '{fmt: 2'd0, hdr: 1'b1};
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_FORMAT: r_cfg.fmt <= i_cfg_wdata;
                    CFG_HEADER: r_cfg.hdr <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (done) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_odata <= {res.changed, res.st, res.rv, res.mask};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odata};
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench of the bad-sector map engine: directed table, then random phases.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import bsme_pkg::*;

    localparam logic [1:0]  FMT_MASK = 2'd0;
    localparam logic [1:0]  FMT_ALT  = 2'd3;
    localparam int unsigned SECT_MAX = 32'h7FFFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [1:0]  i_cfg_wdata = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // segment, new_mask, byte_index, byte_value
    logic [1:0]  s_axis_tuser = '0;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // mask, read_value, status, changed

    bad_sector_map_engine DUT (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [7:0]  map_img [MAP_BYTES];
    int unsigned cursor, last_seg, cached, changed_flag;
    logic [1:0]  fmt;
    logic        hdr;

    t_res result_q [$];
    int   errors = 0;
    int   burst_left = 0;

    function automatic int unsigned rd_ent(int unsigned p);
        if (p > MAP_BYTES - 3) return 0;
        return {8'h00, map_img[p+2], map_img[p+1], map_img[p]};
    endfunction

    function automatic void wr_ent(int unsigned p, int unsigned s);
        if (p > MAP_BYTES - 3) return;
        map_img[p] = s[7:0];
        map_img[p+1] = s[15:8];
        map_img[p+2] = s[23:16];
    endfunction

    function automatic int unsigned sect_seg(int unsigned s);
        return (((s & SECT_MAX) - 1) & SECT_MAX) >> 5;
    endfunction

    function automatic int unsigned sect_bit(int unsigned s);
        return 32'd1 << (((s & SECT_MAX) - 1) & 31);
    endfunction

    // Walks forward to the first entry of seg or beyond; returns the entry count of seg.
    function automatic int unsigned seek_fwd(input int unsigned seg, inout int unsigned pos,
                                             output int unsigned m);
        int unsigned p, s, sg, start, cnt;
        p = pos;
        m = 0;
        cnt = 0;
        do begin
            s = rd_ent(p);
            p += 3;
            sg = sect_seg(s);
        end while (s != 0 && sg < seg);
        start = p - 3;
        if (fmt == FMT_FLAG && s[23] && sg == seg) begin
            m = ALL_ONES;
            cnt = 1;
        end else begin
            while (s != 0 && sg == seg) begin
                m |= sect_bit(s);
                s = rd_ent(p);
                p += 3;
                sg = sect_seg(s);
                cnt++;
            end
        end
        pos = start;
        return cnt;
    endfunction

    function automatic int unsigned seek_back(input int unsigned seg, inout int unsigned pos);
        int unsigned p, s, sg, m;
        p = pos;
        m = 0;
        if (p >= 3) begin
            do begin
                p -= 3;
                s = rd_ent(p);
                sg = sect_seg(s);
            end while (p >= 3 && sg > seg);
            if (sg > seg) begin
            end else if (sg < seg) begin
                p += 3;
            end else if (fmt == FMT_FLAG && s[23]) begin
                m = ALL_ONES;
            end else begin
                do begin
                    m |= sect_bit(s);
                    if (p < 3) break;
                    p -= 3;
                    s = rd_ent(p);
                    sg = sect_seg(s);
                end while (sg == seg);
                if (sg < seg) p += 3;
            end
        end
        pos = p;
        return m;
    endfunction

    // Rewrites the entries of one segment; returns 1 when the put is refused.
    function automatic logic list_put(int unsigned seg, logic [31:0] nm);
        int unsigned q, old_m, cnt, n, hi, e, src, dst, len;
        logic flagged;
        n = $countones(nm);
        flagged = (fmt == FMT_FLAG && n == 32);
        if (!flagged && nm != 0) begin
            hi = 31;
            while (!nm[hi]) hi--;
            if (1 + seg * 32 + hi > SECT_MAX) return 1'b1;
        end
        q = 0;
        cnt = seek_fwd(seg, q, old_m);
        if (flagged) n = 1;
        if (cnt != n) begin
            e = q;
            while (e <= MAP_BYTES - 3 && rd_ent(e) != 0) e += 3;
            if (e > MAP_BYTES - 3) return 1'b1;
            if (e - 3 * cnt + 3 * n > MAP_BYTES - 3) return 1'b1;
            src = q + 3 * cnt;
            dst = q + 3 * n;
            len = e + 3 - src;
            if (dst < src) begin
                for (int unsigned k = 0; k < len; k++) map_img[dst+k] = map_img[src+k];
            end else begin
                for (int unsigned k = len; k > 0; k--) map_img[dst+k-1] = map_img[src+k-1];
            end
        end
        if (flagged) begin
            wr_ent(q, FLAG_BIT + 1 + seg * 32);
        end else begin
            for (int unsigned i = 0; i < 32; i++) begin
                if (nm[i]) begin
                    wr_ent(q, 1 + seg * 32 + i);
                    q += 3;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_res map_engine_step(t_req r);
        t_res        o;
        logic        list;
        int unsigned a, seg;
        o = '0;
        seg = r.seg;
        list = (fmt == FMT_LIST || fmt == FMT_FLAG);
        case (r.op)
            OP_LOAD: map_img[r.idx] = r.bv;
            OP_READ: o.rv = map_img[r.idx];
            OP_GET: begin
                if (hdr) begin
                    cached = 0;
                end else if (list) begin
                    if (last_seg == SEG_NONE || seg > last_seg)
                        void'(seek_fwd(seg, cursor, cached));
                    else if (seg < last_seg)
                        cached = seek_back(seg, cursor);
                    last_seg = seg;
                end else begin
                    a = seg * 4;
                    if (a > MAP_BYTES - 4) o.st = 1'b1;
                    else cached = {map_img[a+3], map_img[a+2], map_img[a+1], map_img[a]};
                end
                if (!o.st) o.mask = cached;
            end
            default: begin
                if (list) begin
                    o.st = list_put(seg, r.nm);
                end else begin
                    a = seg * 4;
                    if (a > MAP_BYTES - 4) begin
                        o.st = 1'b1;
                    end else begin
                        {map_img[a+3], map_img[a+2], map_img[a+1], map_img[a]} = r.nm;
                    end
                end
                if (!o.st) begin
                    changed_flag = 1;
                    cursor = 0;
                    last_seg = SEG_NONE;
                    cached = 0;
                end
            end
        endcase
        o.changed = changed_flag[0];
        return o;
    endfunction

    // Sends one request; the expectation is queued at the accepting edge.
    task automatic send_request(t_req r, logic typed, t_res typed_res);
        t_res p;
        int   gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {7'd0, r.bv, r.idx, r.nm, r.seg};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = map_engine_step(r);
        result_q.push_back(typed ? typed_res : p);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 12);
        end else begin
            gap = 0;
        end
        burst_left--;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Settings change only once the engine has drained.
    task automatic set_cfg(logic [1:0] f, logic h);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_FORMAT;
        i_cfg_wdata <= f;
        @(posedge i_clk);
        i_cfg_addr <= CFG_HEADER;
        i_cfg_wdata <= {1'b0, h};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fmt = f;
        hdr = h;
    endtask

    // Result checker with its own stall pattern.
    int stall_mode = 0;
    int cyc = 0;
    always @(posedge i_clk) begin
        t_res got, want;
        cyc <= cyc + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{mask: m_axis_tdata[31:0], rv: m_axis_tdata[39:32],
                    st: m_axis_tdata[40], changed: m_axis_tdata[41]};
            if (result_q.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (got.mask != want.mask) begin
                    $error("mask: expected %h, got %h", want.mask, got.mask);
                    errors++;
                end
                if (got.rv != want.rv) begin
                    $error("read_value: expected %h, got %h", want.rv, got.rv);
                    errors++;
                end
                if (got.st != want.st) begin
                    $error("status: expected %0d, got %0d", want.st, got.st);
                    errors++;
                end
                if (got.changed != want.changed) begin
                    $error("changed: expected %0d, got %0d", want.changed, got.changed);
                    errors++;
                end
            end
        end
        if (cyc % 128 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) != 0);
            default: m_axis_tready <= (cyc % 16 < 3);
        endcase
    end

    typedef struct {
        logic [1:0]  f;
        logic        h;
        t_req        r;
        logic        typed;
        t_res        res;
    } t_row;

    t_row rows [$];

    task automatic add_row(logic [1:0] f, logic h, t_op op, logic [17:0] seg, logic [31:0] nm,
                           logic [14:0] idx, logic [7:0] bv, logic typed = 1'b0,
                           logic [31:0] m = 0, logic [7:0] rv = 0, logic st = 0,
                           logic ch = 0);
        t_row w;
        w.f = f;
        w.h = h;
        w.r = '{op: op, seg: seg, nm: nm, idx: idx, bv: bv};
        w.typed = typed;
        w.res = '{mask: m, rv: rv, st: st, changed: ch};
        rows.push_back(w);
    endtask

    initial begin
        t_req        r;
        int unsigned pick;
        logic [1:0]  pf [8] = '{FMT_MASK, FMT_LIST, FMT_FLAG, FMT_LIST,
                                FMT_ALT, FMT_FLAG, FMT_MASK, FMT_LIST};
        logic        ph [8] = '{0, 0, 0, 1, 0, 0, 1, 0};

        foreach (map_img[k]) map_img[k] = 8'h00;
        cursor = 0;
        last_seg = SEG_NONE;
        cached = 0;
        changed_flag = 0;
        fmt = FMT_MASK;
        hdr = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Header pending and byte access at the top of the store.
        add_row(FMT_MASK, 1, OP_GET, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(FMT_MASK, 1, OP_READ, 0, 0, 15'h7FFF, 0, 1, 0, 0, 0, 0);
        add_row(FMT_MASK, 1, OP_LOAD, 0, 0, 15'h7FFF, 8'hFF, 1, 0, 0, 0, 0);
        add_row(FMT_MASK, 1, OP_READ, 0, 0, 15'h7FFF, 0, 1, 0, 8'hFF, 0, 0);
        // Mask words, including the last word and words beyond the store.
        add_row(FMT_MASK, 0, OP_PUT, 0, 32'hFFFFFFFF, 0, 0, 1, 0, 0, 0, 1);
        add_row(FMT_MASK, 0, OP_GET, 0, 0, 0, 0, 1, 32'hFFFFFFFF, 0, 0, 1);
        add_row(FMT_MASK, 0, OP_PUT, 18'h1FFF, 32'h80000001, 0, 0);
        add_row(FMT_MASK, 0, OP_GET, 18'h1FFF, 0, 0, 0);
        add_row(FMT_MASK, 0, OP_GET, 18'h2000, 0, 0, 0, 1, 0, 0, 1, 1);
        add_row(FMT_MASK, 0, OP_PUT, 18'h3FFFF, 32'h1234, 0, 0, 1, 0, 0, 1, 1);
        add_row(FMT_MASK, 0, OP_PUT, 0, 0, 0, 0);
        // Sector list: forward and backward seeks, cached answer, sector too high.
        add_row(FMT_LIST, 0, OP_PUT, 3, 32'h80000005, 0, 0);
        add_row(FMT_LIST, 0, OP_PUT, 1, 32'h00010000, 0, 0);
        add_row(FMT_LIST, 0, OP_GET, 3, 0, 0, 0);
        add_row(FMT_LIST, 0, OP_GET, 1, 0, 0, 0);
        add_row(FMT_LIST, 0, OP_GET, 3, 0, 0, 0);
        add_row(FMT_LIST, 0, OP_GET, 3, 0, 0, 0);
        add_row(FMT_LIST, 0, OP_PUT, 18'h3FFFF, 32'h80000000, 0, 0, 1, 0, 0, 1, 1);
        add_row(FMT_LIST, 0, OP_PUT, 18'h3FFFF, 32'h1, 0, 0);
        add_row(FMT_LIST, 0, OP_PUT, 3, 0, 0, 0);
        // Whole-segment entries and an entry of sector zero.
        add_row(FMT_FLAG, 0, OP_PUT, 2, 32'hFFFFFFFF, 0, 0);
        add_row(FMT_FLAG, 0, OP_GET, 2, 0, 0, 0);
        add_row(FMT_FLAG, 0, OP_LOAD, 0, 0, 0, 8'h00);
        add_row(FMT_FLAG, 0, OP_LOAD, 0, 0, 2, 8'h80);
        add_row(FMT_FLAG, 0, OP_GET, 18'h3FFFF, 0, 0, 0);
        // The unused format code acts as mask words.
        add_row(FMT_ALT, 1, OP_GET, 5, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(FMT_ALT, 0, OP_PUT, 5, 32'hA5A5A5A5, 0, 0);
        add_row(FMT_ALT, 0, OP_GET, 5, 0, 0, 0);

        set_cfg(FMT_MASK, 1'b1);
        foreach (rows[i]) begin
            if (rows[i].f != fmt || rows[i].h != hdr) set_cfg(rows[i].f, rows[i].h);
            send_request(rows[i].r, rows[i].typed, rows[i].res);
        end

        for (int ph_i = 0; ph_i < 8; ph_i++) begin
            set_cfg(pf[ph_i], ph[ph_i]);
            for (int n = 0; n < 225; n++) begin
                pick = $urandom_range(0, 99);
                r.op = pick < 10 ? OP_LOAD : pick < 20 ? OP_READ : pick < 60 ? OP_GET : OP_PUT;
                pick = $urandom_range(0, 99);
                if (fmt == FMT_LIST || fmt == FMT_FLAG)
                    r.seg = 18'(pick < 85 ? $urandom_range(0, 15) :
                                pick < 95 ? $urandom_range(0, 18'h3FFFF) : 18'h3FFFF);
                else
                    r.seg = 18'(pick < 90 ? $urandom_range(0, 63) :
                                pick < 95 ? $urandom_range(18'h1FFE, 18'h2001) :
                                            $urandom_range(0, 18'h3FFFF));
                pick = $urandom_range(0, 99);
                // Sparse masks keep the lists short.
                r.nm = pick < 50 ? (32'd1 << $urandom_range(0, 31)) |
                                   (32'd1 << $urandom_range(0, 31)) :
                       pick < 65 ? 32'd0 : pick < 80 ? 32'hFFFFFFFF : $urandom;
                r.idx = 15'($urandom_range(0, 1) ? $urandom_range(0, 255) :
                                                   $urandom_range(0, 32767));
                r.bv = 8'($urandom_range(0, 255));
                send_request(r, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
